// ===== hdl/bls_pkg.sv =====
// Package for the battery level smoother: level constants, register indexes
// and small arithmetic helpers. No dependencies.
package bls_pkg;

   localparam int LevelWidth  = 7;
   localparam int RawWidth    = 8;
   localparam int CountWidth  = 12;
   localparam int BadWidth    = 3;

   localparam logic [RawWidth-1:0]   FullLevel      = 8'd100;
   localparam logic [RawWidth-1:0]   CreepUpFloor   = 8'd95;
   localparam logic [RawWidth-1:0]   CreepDownFloor = 8'd90;
   localparam logic [RawWidth-1:0]   DisplayOffset  = 8'd5;
   localparam logic [BadWidth-1:0]   BadReadLimit   = 3'd5;
   localparam logic [CountWidth-1:0] CountMax       = 12'd4095;

   localparam logic [CountWidth-1:0] UpCreepReset   = 12'd720;
   localparam logic [CountWidth-1:0] DownCreepReset = 12'd60;
   localparam logic [CountWidth-1:0] StuckZeroReset = 12'd1800;
   localparam logic [LevelWidth-1:0] LevelReset     = 7'd2;

   typedef enum logic [1:0] {
      CSR_UP_CREEP   = 2'd0,
      CSR_DOWN_CREEP = 2'd1,
      CSR_STUCK_ZERO = 2'd2
   } csr_index_type;

   // Saturating increment of a poll counter.
   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
      return (v < CountMax) ? v + 12'd1 : CountMax;
   endfunction

   // Shown level plus the display offset, capped at full.
   function automatic logic [LevelWidth-1:0] display_of(input logic [LevelWidth-1:0] lvl);
      logic [RawWidth-1:0] sum;
      sum = {1'b0, lvl} + DisplayOffset;
      if (sum > FullLevel) begin
         sum = FullLevel;
      end
      return sum[LevelWidth-1:0];
   endfunction

endpackage

// ===== hdl/battery_level_smoother.sv =====
// Battery level smoother top level: input register, one pass of smoothing
// logic and a result register. Depends on bls_pkg.
//
// The block takes one gauge poll per request (raw state-of-charge byte and
// charger-present bit) and returns one result per request: the smoothed
// level, the display level (smoothed level plus five, capped at 100), a
// gauge restart request and a flag that the raw reading was above 100 and
// was ignored. It accepts one request every clock cycle while the result side
// is not stalled; each request passes through the input register and then the
// result register, and the smoothing state is updated as the request moves from
// the one to the other. The result register lets the input register take a new
// request while a result waits, but once both hold a request the request side
// stalls until the result is taken. The three period registers are written
// through the csr_ port and must only be changed while no request is in flight.
module battery_level_smoother
   import bls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Configuration write port.
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [11:0] csr_wdata,
   // Request channel. tdata: [7:0] raw_level, [8] charger_present, [15:9] zero.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // Result channel. tdata: [6:0] shown_level, [13:7] display_level,
   // [14] restart_request, [15] reading_invalid.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata
);

   // Configuration registers.
   logic [CountWidth-1:0] up_period_ff, down_period_ff, zero_limit_ff;

   // Input stage.
   logic                in_valid_ff, in_valid_in;
   logic [RawWidth-1:0] in_raw_ff;
   logic                in_usb_ff;

   // Smoothing state.
   logic [LevelWidth-1:0] stored_level_ff, stored_level_in;
   logic [BadWidth-1:0]   bad_count_ff, bad_count_in;
   logic [CountWidth-1:0] creep_count_ff, creep_count_in;
   logic                  faked_full_ff, faked_full_in;
   logic [CountWidth-1:0] zero_count_ff, zero_count_in;
   logic                  restart_done_ff, restart_done_in;

   // Result stage.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LevelWidth-1:0] rsp_shown_ff, rsp_shown_in;
   logic                  rsp_restart_ff, rsp_restart_in;
   logic                  rsp_invalid_ff, rsp_invalid_in;

   logic req_accept;
   logic out_load;
   logic advance;

   // The result register can take a new value when empty or being drained.
   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_load;
   assign req_tready = !in_valid_ff || out_load;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // One pass of the smoothing rules over the request in the input register.
   always_comb begin
      logic [RawWidth-1:0]   s;
      logic [RawWidth-1:0]   c;
      logic [RawWidth-1:0]   lower;
      logic [BadWidth-1:0]   bad_next;
      logic [CountWidth-1:0] creep_next;
      logic [CountWidth-1:0] zero_next;
      logic                  allowed;

      s          = {1'b0, stored_level_ff};
      c          = in_raw_ff;
      lower      = s - 8'd1;
      bad_next   = bad_count_ff + 3'd1;
      creep_next = sat_inc(creep_count_ff);
      zero_next  = sat_inc(zero_count_ff);
      allowed    = 1'b0;

      stored_level_in = stored_level_ff;
      bad_count_in    = bad_count_ff;
      creep_count_in  = creep_count_ff;
      faked_full_in   = faked_full_ff;
      zero_count_in   = zero_count_ff;
      restart_done_in = restart_done_ff;
      rsp_shown_in    = stored_level_ff;
      rsp_restart_in  = 1'b0;
      rsp_invalid_in  = 1'b0;

      if (in_raw_ff > FullLevel) begin
         // Out-of-range reading: keep the level, count toward a restart.
         rsp_invalid_in = 1'b1;
         bad_count_in   = bad_next;
         if (bad_next > BadReadLimit) begin
            rsp_restart_in = 1'b1;
            bad_count_in   = '0;
         end
      end else begin
         bad_count_in = '0;

         // Hold back a one-step swing against the charge direction, except
         // when stepping onto empty from a low level or onto full from 99.
         if ((in_usb_ff && (c + 8'd1 == s)) || (!in_usb_ff && (c == s + 8'd1))) begin
            allowed = ((c == 8'd0) && (s <= 8'd2)) ||
                      ((c == FullLevel) && (s == FullLevel - 8'd1));
            if (!allowed) begin
               c = s;
            end
         end

         if (in_usb_ff && (c >= CreepUpFloor) && (c <= s)) begin
            // Near full while charging: creep up one step per period.
            creep_count_in = creep_next;
            if (creep_next >= up_period_ff) begin
               c              = (s + 8'd1 <= FullLevel) ? s + 8'd1 : FullLevel;
               faked_full_in  = 1'b1;
               creep_count_in = '0;
            end else begin
               c = s;
            end
         end else if (!in_usb_ff && (c <= s) && (c >= CreepDownFloor) && faked_full_ff) begin
            // After a faked full: ramp back down toward the true reading.
            creep_count_in = creep_next;
            if (creep_next >= down_period_ff) begin
               creep_count_in = '0;
               if (c >= lower) begin
                  faked_full_in = 1'b0;
               end else begin
                  c = lower;
               end
            end else begin
               c = s;
            end
         end else begin
            creep_count_in = '0;
         end

         // Stuck at zero while charging: one restart per charging session.
         if (in_usb_ff && (c == 8'd0)) begin
            zero_count_in = zero_next;
            if ((zero_next >= zero_limit_ff) && !restart_done_ff) begin
               rsp_restart_in  = 1'b1;
               restart_done_in = 1'b1;
               zero_count_in   = '0;
            end
         end else if (restart_done_ff && !in_usb_ff) begin
            restart_done_in = 1'b0;
         end

         stored_level_in = c[LevelWidth-1:0];
         rsp_shown_in    = c[LevelWidth-1:0];
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         stored_level_ff <= LevelReset;
         bad_count_ff    <= '0;
         creep_count_ff  <= '0;
         faked_full_ff   <= 1'b0;
         zero_count_ff   <= '0;
         restart_done_ff <= 1'b0;
         up_period_ff    <= UpCreepReset;
         down_period_ff  <= DownCreepReset;
         zero_limit_ff   <= StuckZeroReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            stored_level_ff <= stored_level_in;
            bad_count_ff    <= bad_count_in;
            creep_count_ff  <= creep_count_in;
            faked_full_ff   <= faked_full_in;
            zero_count_ff   <= zero_count_in;
            restart_done_ff <= restart_done_in;
         end
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_UP_CREEP:   up_period_ff   <= csr_wdata;
               CSR_DOWN_CREEP: down_period_ff <= csr_wdata;
               CSR_STUCK_ZERO: zero_limit_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_raw_ff <= req_tdata[7:0];
         in_usb_ff <= req_tdata[8];
      end
      if (advance) begin
         rsp_shown_ff   <= rsp_shown_in;
         rsp_restart_ff <= rsp_restart_in;
         rsp_invalid_ff <= rsp_invalid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_invalid_ff, rsp_restart_ff, display_of(rsp_shown_ff), rsp_shown_ff};

   // The bad-read counter resets once it passes the limit.
   assert property (@(posedge clock) disable iff (reset) bad_count_ff <= BadReadLimit)
      else $error("bad read count above limit");

   // The stored level never leaves the percentage range.
   assert property (@(posedge clock) disable iff (reset) {1'b0, stored_level_ff} <= FullLevel)
      else $error("stored level above full");

   // A request held in the input register is not dropped while the result side stalls.
   assert property (@(posedge clock) disable iff (reset)
                    in_valid_ff && !out_load |=> in_valid_ff)
      else $error("request lost while stalled");

   // A reading that was ignored leaves the shown level unchanged.
   assert property (@(posedge clock) disable iff (reset)
                    advance && rsp_invalid_in |=> rsp_shown_ff == $past(stored_level_ff))
      else $error("ignored reading changed the level");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for battery_level_smoother: a directed opening, mixed random
// phases under several period settings, and a short stuck-at-zero re-arm check.
// Needs bls_pkg.
module tb_top;
   import bls_pkg::*;

   // Index 3 of the register port has no register behind it; writes to it are dropped.
   localparam logic [1:0] CsrSpare = 2'd3;

   // One result word, laid out from the top bit down so that it matches rsp_tdata.
   typedef struct packed {
      logic                  invalid;
      logic                  restart;
      logic [LevelWidth-1:0] display;
      logic [LevelWidth-1:0] shown;
   } poll_result_type;

   // Tracks the smoothing state, predicts one result per accepted request and checks
   // every result that the block hands out against the oldest prediction.
   class level_tracker;
      logic [CountWidth-1:0] up_period;
      logic [CountWidth-1:0] down_period;
      logic [CountWidth-1:0] zero_limit;
      logic [LevelWidth-1:0] level;
      logic [BadWidth-1:0]   bad_reads;
      logic [CountWidth-1:0] creep_polls;
      logic [CountWidth-1:0] zero_polls;
      logic                  faked_full;
      logic                  restart_sent;
      poll_result_type       due[$];
      int                    errors;
      int                    polls_checked;
      int                    restarts_seen;
      int                    invalid_seen;

      function void power_up();
         up_period    = UpCreepReset;
         down_period  = DownCreepReset;
         zero_limit   = StuckZeroReset;
         level        = LevelReset;
         bad_reads    = '0;
         creep_polls  = '0;
         zero_polls   = '0;
         faked_full   = 1'b0;
         restart_sent = 1'b0;
         due.delete();
      endfunction

      function void set_periods(logic [CountWidth-1:0] up, logic [CountWidth-1:0] down,
                                logic [CountWidth-1:0] zlim);
         up_period   = up;
         down_period = down;
         zero_limit  = zlim;
      endfunction

      function logic [CountWidth-1:0] bump(logic [CountWidth-1:0] v);
         return (v == CountMax) ? v : v + 1'b1;
      endfunction

      function void queue_result(int lvl, logic restart, logic invalid);
         poll_result_type r;
         int              disp;
         disp      = lvl + DisplayOffset;
         r.shown   = LevelWidth'(lvl);
         r.display = LevelWidth'((disp > FullLevel) ? FullLevel : disp);
         r.restart = restart;
         r.invalid = invalid;
         due.push_back(r);
      endfunction

      function void note_poll(logic [RawWidth-1:0] raw, logic usb);
         int   cur;
         int   cand;
         logic restart;
         cur     = level;
         restart = 1'b0;
         if (raw > FullLevel) begin
            // Out-of-range reading: the level holds and the rest is skipped.
            bad_reads = bad_reads + 1'b1;
            if (bad_reads > BadReadLimit) begin
               restart   = 1'b1;
               bad_reads = '0;
            end
            queue_result(cur, restart, 1'b1);
            return;
         end
         bad_reads = '0;
         cand      = raw;
         // One-step moves against the charge direction are held, except the moves
         // down to zero from a very low level and up to full from 99.
         if ((usb && cand + 1 == cur) || (!usb && cand == cur + 1)) begin
            if (!((cand == 0 && cur <= 2) || (cand == FullLevel && cur == FullLevel - 1)))
               cand = cur;
         end
         if (usb && cand >= CreepUpFloor && cand <= cur) begin
            creep_polls = bump(creep_polls);
            if (creep_polls >= up_period) begin
               cand        = (cur + 1 <= FullLevel) ? cur + 1 : FullLevel;
               faked_full  = 1'b1;
               creep_polls = '0;
            end else begin
               cand = cur;
            end
         end else if (!usb && cand <= cur && cand >= CreepDownFloor && faked_full) begin
            creep_polls = bump(creep_polls);
            if (creep_polls >= down_period) begin
               creep_polls = '0;
               if (cand >= cur - 1)
                  faked_full = 1'b0;
               else
                  cand = cur - 1;
            end else begin
               cand = cur;
            end
         end else begin
            creep_polls = '0;
         end
         if (usb && cand == 0) begin
            zero_polls = bump(zero_polls);
            if (zero_polls >= zero_limit && !restart_sent) begin
               restart      = 1'b1;
               restart_sent = 1'b1;
               zero_polls   = '0;
            end
         end else if (restart_sent && !usb) begin
            restart_sent = 1'b0;
         end
         level = LevelWidth'(cand);
         queue_result(cand, restart, 1'b0);
      endfunction

      task report(string what);
         if (errors < 40)
            $display("MISMATCH at %0t ns: %s", $time, what);
         errors++;
      endtask

      task check_level(logic [15:0] word);
         poll_result_type got;
         poll_result_type want;
         got = poll_result_type'(word);
         polls_checked++;
         if (got.restart)
            restarts_seen++;
         if (got.invalid)
            invalid_seen++;
         if (due.size() == 0) begin
            report("result arrived with no request outstanding");
            return;
         end
         want = due.pop_front();
         if (got.shown !== want.shown)
            report($sformatf("shown_level %0d, predicted %0d", got.shown, want.shown));
         if (got.display !== want.display)
            report($sformatf("display_level %0d, predicted %0d", got.display, want.display));
         if (got.restart !== want.restart)
            report($sformatf("restart_request %b, predicted %b", got.restart, want.restart));
         if (got.invalid !== want.invalid)
            report($sformatf("reading_invalid %b, predicted %b", got.invalid, want.invalid));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [11:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [7:0] raw_level, [8] charger_present, [15:9] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [6:0] shown_level, [13:7] display_level,
                             // [14] restart_request, [15] reading_invalid

   level_tracker tracker = new;
   logic         idle_on = 1'b1;   // cleared for stretches that run back to back
   int           stall_left = 0;
   int           settings_used = 1;

   battery_level_smoother u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Length of a pause on either side: mostly none, often short, and now and then
   // a long one. While idling is off, both sides run flat out.
   function automatic int pick_gap();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // The result side stalls independently of the request side. Its ready changes on
   // the falling edge, so it is settled well before the block samples it.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // Both handshakes are observed at the rising edge, where they complete. The
   // prediction for a request is queued before any result of the same edge is checked.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         tracker.note_poll(req_tdata[RawWidth-1:0], req_tdata[RawWidth]);
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_level(rsp_tdata);
   end

   // Offers one request, after a random pause, and returns at the falling edge that
   // follows its acceptance. Valid stays high between back-to-back requests.
   task automatic drive_poll(input logic [RawWidth-1:0] raw, input logic usb);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, usb, raw};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stops sending and waits, with a bound, until every predicted result is back,
   // then lets the two-stage pipeline run empty before anything else happens.
   task automatic settle();
      int waited;
      req_tvalid <= 1'b0;
      waited = 0;
      while (tracker.due.size() != 0 && waited < 3000) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(negedge clock);
   endtask

   // Writes the three period registers on consecutive cycles, plus a write of random
   // data to the spare index, which must not disturb anything.
   task automatic load_periods(input logic [CountWidth-1:0] up,
                               input logic [CountWidth-1:0] down,
                               input logic [CountWidth-1:0] zlim);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_UP_CREEP;
      csr_wdata <= up;
      @(negedge clock);
      csr_addr  <= CSR_DOWN_CREEP;
      csr_wdata <= down;
      @(negedge clock);
      csr_addr  <= CSR_STUCK_ZERO;
      csr_wdata <= zlim;
      @(negedge clock);
      csr_addr  <= CsrSpare;
      csr_wdata <= 12'($urandom);
      @(negedge clock);
      csr_we <= 1'b0;
      tracker.set_periods(up, down, zlim);
      settings_used++;
      @(negedge clock);
   endtask

   // Random traffic built from short runs of one kind each. Most runs are the
   // sequences that drive the state machine somewhere: charging near full (creep up),
   // discharging from 88 up to full (creep down after a faked full), charging at zero
   // (stuck gauge), bursts of out-of-range readings and one-step swings around the
   // current level. The rest is unshaped noise.
   task automatic run_mix(input int polls);
      int                  sent;
      int                  run;
      int                  kind;
      int                  lvl;
      int                  i;
      logic                usb;
      logic [RawWidth-1:0] raw;
      sent = 0;
      while (sent < polls) begin
         kind    = $urandom_range(0, 99);
         run     = $urandom_range(1, 12);
         idle_on = ($urandom_range(0, 3) != 0);
         for (i = 0; i < run; i++) begin
            lvl = tracker.level;
            if (kind < 35) begin
               usb = 1'b1;
               raw = RawWidth'($urandom_range(93, 100));
            end else if (kind < 55) begin
               usb = 1'b0;
               raw = RawWidth'($urandom_range(88, 100));
            end else if (kind < 68) begin
               usb = 1'b1;
               raw = ($urandom_range(0, 5) == 0) ? 8'd1 : 8'd0;
            end else if (kind < 78) begin
               usb = 1'($urandom_range(0, 1));
               raw = RawWidth'($urandom_range(101, 255));
            end else if (kind < 90) begin
               // Step against the charge direction from wherever the level is now.
               usb = 1'($urandom_range(0, 1));
               if (usb)
                  raw = RawWidth'((lvl == 0) ? 0 : lvl - 1);
               else
                  raw = RawWidth'((lvl >= FullLevel) ? FullLevel : lvl + 1);
            end else begin
               usb = 1'($urandom_range(0, 1));
               raw = RawWidth'($urandom_range(0, 255));
            end
            drive_poll(raw, usb);
         end
         sent += run;
      end
   endtask

   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      tracker.power_up();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening with the reset periods, starting from a shown level of two.
      drive_poll(8'd255, 1'b0);   // every raw bit high, ignored
      drive_poll(8'd101, 1'b1);   // just above full, ignored
      drive_poll(8'd0, 1'b0);     // discharging to zero
      drive_poll(8'd0, 1'b1);     // charging at zero, stuck counter starts
      drive_poll(8'd100, 1'b1);   // jump to full, display capped
      drive_poll(8'd99, 1'b1);    // dip while charging is held, creep starts
      drive_poll(8'd100, 1'b1);
      repeat (6) drive_poll(8'd101, 1'b1);   // sixth bad reading in a row asks a restart
      drive_poll(8'd50, 1'b0);
      drive_poll(8'd51, 1'b0);    // rise while discharging is held
      drive_poll(8'd49, 1'b1);    // dip while charging is held
      drive_poll(8'd1, 1'b0);
      drive_poll(8'd2, 1'b0);     // held again
      drive_poll(8'd0, 1'b1);     // one step down to zero from a low level passes
      drive_poll(8'd99, 1'b0);
      drive_poll(8'd100, 1'b0);   // the last step up to full passes while discharging
      drive_poll(8'd96, 1'b0);
      drive_poll(8'd97, 1'b1);
      drive_poll(8'd170, 1'b1);   // alternating bit pattern, ignored
      drive_poll(8'd85, 1'b0);

      // Random phases under a range of period settings, the extremes among them.
      // A zero period or limit must behave as a period of one.
      run_mix(120);
      settle();
      load_periods(12'd1, 12'd1, 12'd1);
      run_mix(130);
      settle();
      load_periods(12'd0, 12'd0, 12'd0);
      run_mix(100);
      settle();
      load_periods(12'd3, 12'd5, 12'd7);
      run_mix(130);
      settle();
      load_periods(12'd4095, 12'd4095, 12'd4095);
      run_mix(100);
      settle();
      load_periods(12'($urandom_range(1, 12)), 12'($urandom_range(1, 12)),
                   12'($urandom_range(0, 4095)));
      run_mix(120);

      // Stuck at zero while charging with a limit of one: the first zero poll asks
      // for a restart, unless the session already had one, and the following ones stay
      // quiet, until a discharging poll re-arms the request for the next charging session.
      settle();
      load_periods(12'd1, 12'd1, 12'd1);
      repeat (5) drive_poll(8'd0, 1'b1);
      drive_poll(8'd0, 1'b0);
      repeat (3) drive_poll(8'd0, 1'b1);

      settle();
      if (tracker.due.size() != 0)
         tracker.report($sformatf("%0d predicted results never arrived", tracker.due.size()));
      $display("Summary: %0d polls checked under %0d period settings, reset values included.",
               tracker.polls_checked, settings_used);
      $display("Summary: %0d gauge restart requests and %0d ignored readings observed.",
               tracker.restarts_seen, tracker.invalid_seen);
      if (tracker.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, even with every pause at its longest.
   initial begin
      #(10_000_000);
      $display("Timeout: the run did not finish in time.");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/bls_pkg.sv
hdl/battery_level_smoother.sv
bench/tb_top.sv
